FILE: rtl/core/dlre_pkg.sv
// shared types and constants for the resolution list range expander
`timescale 1ns / 1ps
`default_nettype none

package dlre_pkg;

	localparam int WORD_W   = 16;
	localparam int STEP_W   = 13;
	localparam int CAP_W    = 7;
	localparam int KIND_W   = 2;
	localparam int ERR_W    = 3;

	localparam int DEF_MAX_RAW_WORDS = 8;
	localparam int DEF_MAX_VALUES    = 64;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
	localparam logic [WORD_W-STEP_W-1:0] STEP_TAG = 3'b111;

	localparam logic [KIND_W-1:0] KIND_VALUE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OK    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FAIL  = 2'd2;

	localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
	localparam logic [ERR_W-1:0] ERR_NO_BASE    = 3'd1;
	localparam logic [ERR_W-1:0] ERR_UNTERM     = 3'd2;
	localparam logic [ERR_W-1:0] ERR_ZERO_STEP  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_END_BELOW  = 3'd4;
	localparam logic [ERR_W-1:0] ERR_CAPACITY   = 3'd5;
	localparam logic [ERR_W-1:0] ERR_EMPTY      = 3'd6;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic eval;
		logic run;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic to_run;
		logic to_idle;
		logic run_exit;
		logic fin_exit;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/dlre_ctrl.sv
// controller state machine for the resolution list range expander
`timescale 1ns / 1ps
`default_nettype none

module dlre_ctrl
	import dlre_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_RUN  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.eval    = (state_q == ST_EVAL);
		cmd.run     = (state_q == ST_RUN);
		cmd.finish  = (state_q == ST_FIN);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (sts.to_idle) state_d = ST_IDLE;
				else if (sts.to_run) state_d = ST_RUN;
				else state_d = ST_FIN;
			end
			ST_RUN: begin
				if (sts.run_exit) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (sts.fin_exit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/dlre_dpath.sv
// datapath: list state, range stepping, result register
`timescale 1ns / 1ps
`default_nettype none

module dlre_dpath
	import dlre_pkg::*;
#(
	parameter int MAX_RAW_WORDS = DEF_MAX_RAW_WORDS,
	parameter int MAX_VALUES    = DEF_MAX_VALUES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CAP_W-1:0]  cfg_wr_data,
	input  wire logic [WORD_W-1:0] raw_word,
	input  wire logic              word_last,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [WORD_W-1:0]      dpi_value,
	output logic [KIND_W-1:0]      kind,
	output logic [ERR_W-1:0]       error_code,
	output logic                   last_of_run
);

	localparam int CNT_W = $clog2(MAX_VALUES + 1);
	localparam int WRD_W = $clog2(MAX_RAW_WORDS + 1);

	logic [CAP_W-1:0]  capacity_q;
	logic [WORD_W-1:0] word_q;
	logic              last_q;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [WORD_W-1:0] prev_q, prev_d;
	logic [STEP_W-1:0] pstep_q, pstep_d;
	logic              pend_q, pend_d;
	logic [WRD_W-1:0]  words_q, words_d;
	logic              stopped_q, stopped_d;
	logic [ERR_W-1:0]  err_q, err_d;
	logic              done_q, done_d;
	logic [WORD_W:0]   next_q, next_d;
	logic [STEP_W-1:0] rstep_q, rstep_d;

	logic              out_valid_q;
	logic [WORD_W-1:0] dpi_value_q;
	logic [KIND_W-1:0] kind_q;
	logic [ERR_W-1:0]  error_code_q;
	logic              last_of_run_q;

	logic              emit;
	logic [WORD_W-1:0] emit_val;
	logic [KIND_W-1:0] emit_kind;
	logic [ERR_W-1:0]  emit_err;
	logic              emit_last;

	logic              out_free;
	logic [CAP_W-1:0]  cap_eff;
	logic              cnt_full;
	logic [WRD_W-1:0]  words_inc;
	logic [ERR_W-1:0]  fin_err;
	logic              next_hits_end;

	assign out_free  = !out_valid_q || !out_stall;
	assign cap_eff   = (capacity_q > CAP_W'(MAX_VALUES)) ? CAP_W'(MAX_VALUES) : capacity_q;
	assign cnt_full  = (CAP_W'(cnt_q) >= cap_eff);
	assign words_inc = words_q + WRD_W'(1);
	assign next_hits_end = (next_q == {1'b0, word_q});

	// status at the end of an item: stream error first, then end-of-list checks
	always_comb begin
		if (err_q != ERR_NONE) fin_err = err_q;
		else if (done_q && pend_q) fin_err = ERR_UNTERM;
		else if (done_q && cnt_q == '0) fin_err = ERR_EMPTY;
		else fin_err = ERR_NONE;
	end

	always_comb begin
		cnt_d     = cnt_q;
		prev_d    = prev_q;
		pstep_d   = pstep_q;
		pend_d    = pend_q;
		words_d   = words_q;
		stopped_d = stopped_q;
		err_d     = err_q;
		done_d    = done_q;
		next_d    = next_q;
		rstep_d   = rstep_q;
		emit      = 1'b0;
		emit_val  = word_q;
		emit_kind = KIND_VALUE;
		emit_err  = ERR_NONE;
		emit_last = 1'b0;
		sts       = '0;

		if (cmd.eval) begin
			err_d  = ERR_NONE;
			done_d = 1'b0;
			if (stopped_q) begin
				// rest of the list is dropped; a last item re-arms for a new list
				if (last_q) stopped_d = 1'b0;
				sts.to_idle = 1'b1;
			end else if (word_q == '0) begin
				done_d = 1'b1;
			end else begin
				words_d = words_inc;
				done_d  = last_q || (words_inc >= WRD_W'(MAX_RAW_WORDS));
				if (pend_q) begin
					pend_d  = 1'b0;
					pstep_d = '0;
					if (pstep_q == '0) begin
						err_d = ERR_ZERO_STEP;
					end else if (word_q < prev_q) begin
						err_d = ERR_END_BELOW;
					end else begin
						next_d     = {1'b0, prev_q} + (WORD_W + 1)'(pstep_q);
						rstep_d    = pstep_q;
						sts.to_run = 1'b1;
					end
				end else if (word_q[WORD_W-1:STEP_W] == STEP_TAG) begin
					if (cnt_q == '0) begin
						err_d = ERR_NO_BASE;
					end else begin
						pstep_d = word_q[STEP_W-1:0];
						pend_d  = 1'b1;
					end
				end else begin
					// a plain word is a run of one value
					next_d     = {1'b0, word_q};
					rstep_d    = STEP_W'(1);
					sts.to_run = 1'b1;
				end
			end
		end else if (cmd.run) begin
			if (next_q <= {1'b0, word_q}) begin
				if (cnt_full) begin
					err_d        = ERR_CAPACITY;
					sts.run_exit = 1'b1;
				end else if (out_free) begin
					emit         = 1'b1;
					emit_val     = next_q[WORD_W-1:0];
					emit_last    = next_hits_end && !done_q;
					cnt_d        = cnt_q + CNT_W'(1);
					prev_d       = next_q[WORD_W-1:0];
					next_d       = next_q + (WORD_W + 1)'(rstep_q);
					sts.run_exit = next_hits_end;
				end
			end else begin
				// run overshot the end value: emit the end value unless already there
				if (prev_q == word_q) begin
					sts.run_exit = 1'b1;
				end else if (cnt_full) begin
					err_d        = ERR_CAPACITY;
					sts.run_exit = 1'b1;
				end else if (out_free) begin
					emit         = 1'b1;
					emit_val     = word_q;
					emit_last    = !done_q;
					cnt_d        = cnt_q + CNT_W'(1);
					prev_d       = word_q;
					sts.run_exit = 1'b1;
				end
			end
		end else if (cmd.finish) begin
			if (fin_err == ERR_NONE && !done_q) begin
				sts.fin_exit = 1'b1;
			end else if (out_free) begin
				emit         = 1'b1;
				emit_val     = '0;
				emit_kind    = (fin_err != ERR_NONE) ? KIND_FAIL : KIND_OK;
				emit_err     = fin_err;
				emit_last    = 1'b1;
				cnt_d        = '0;
				prev_d       = '0;
				pstep_d      = '0;
				pend_d       = 1'b0;
				words_d      = '0;
				stopped_d    = !last_q;
				sts.fin_exit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			cnt_q       <= '0;
			prev_q      <= '0;
			pstep_q     <= '0;
			pend_q      <= 1'b0;
			words_q     <= '0;
			stopped_q   <= 1'b0;
			err_q       <= ERR_NONE;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) capacity_q <= cfg_wr_data;
			cnt_q     <= cnt_d;
			prev_q    <= prev_d;
			pstep_q   <= pstep_d;
			pend_q    <= pend_d;
			words_q   <= words_d;
			stopped_q <= stopped_d;
			err_q     <= err_d;
			done_q    <= done_d;
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			word_q <= raw_word;
			last_q <= word_last;
		end
		next_q  <= next_d;
		rstep_q <= rstep_d;
		if (emit) begin
			dpi_value_q   <= emit_val;
			kind_q        <= emit_kind;
			error_code_q  <= emit_err;
			last_of_run_q <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign dpi_value   = dpi_value_q;
	assign kind        = kind_q;
	assign error_code  = error_code_q;
	assign last_of_run = last_of_run_q;

endmodule

`default_nettype wire

FILE: rtl/core/dpi_list_range_expander.sv
// top level of the resolution list range expander
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   raw_word, word_last
//  out      output     out_valid / out_stall dpi_value, kind, error_code, last_of_run
//  cfg      input      cfg_wr_en             cfg_wr_data (capacity)
//
// an item is accepted and decoded; a plain word or range end is then expanded in the
// run state, one value per cycle while the result register is free, and the finish
// state emits the end-of-item status when the list ends or fails
// out_stall holds the result register and pauses the run until it drains
// arst_n clears the list state and sets capacity to 64
`timescale 1ns / 1ps
`default_nettype none

module dpi_list_range_expander
	import dlre_pkg::*;
#(
	parameter int MAX_RAW_WORDS = DEF_MAX_RAW_WORDS,
	parameter int MAX_VALUES    = DEF_MAX_VALUES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CAP_W-1:0]  cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [WORD_W-1:0] raw_word,
	input  wire logic              word_last,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [WORD_W-1:0]      dpi_value,
	output logic [KIND_W-1:0]      kind,
	output logic [ERR_W-1:0]       error_code,
	output logic                   last_of_run
);

	cmd_t cmd;
	sts_t sts;

	dlre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	dlre_dpath #(
		.MAX_RAW_WORDS (MAX_RAW_WORDS),
		.MAX_VALUES    (MAX_VALUES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.raw_word    (raw_word),
		.word_last   (word_last),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.dpi_value   (dpi_value),
		.kind        (kind),
		.error_code  (error_code),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

FILE: dv/tb.sv
// self-checking testbench for the resolution list range expander
`timescale 1ns / 1ps

module tb;
	import dlre_pkg::*;

	localparam int MAX_WORDS   = DEF_MAX_RAW_WORDS;
	localparam int MAX_VALS    = DEF_MAX_VALUES;
	localparam int SETTLE      = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_ITEMS = 34;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic [KIND_W-1:0] kind;
		logic [ERR_W-1:0]  code;
		logic              last;
	} dpi_result_t;

	class range_scoreboard;
		dpi_result_t awaited[$];
		dpi_result_t held;
		bit          have_held;
		int unsigned capacity;
		int unsigned vals_in_list;
		logic [WORD_W-1:0] prev_value;
		int unsigned step_size;
		bit          step_waiting;
		int unsigned words_in_list;
		bit          stopped;
		int unsigned mismatches;
		int unsigned values_checked;
		int unsigned ends_checked;
		bit [7:0]    codes_seen;

		function new();
			capacity = 32'(CAP_RESET);
			clear_list();
		endfunction

		function void clear_list();
			vals_in_list = 0;
			prev_value = '0;
			step_size = 0;
			step_waiting = 0;
			words_in_list = 0;
			stopped = 0;
		endfunction

		// the final result of an item is only known once the item is fully expanded
		function void queue_result(logic [WORD_W-1:0] v, logic [KIND_W-1:0] k,
				logic [ERR_W-1:0] e);
			if (have_held)
				awaited.push_back(held);
			held = {v, k, e, 1'b0};
			have_held = 1;
		endfunction

		function bit take_value(logic [WORD_W-1:0] v);
			int unsigned cap;
			cap = (capacity > MAX_VALS) ? MAX_VALS : capacity;
			if (vals_in_list >= cap)
				return 0;
			queue_result(v, KIND_VALUE, ERR_NONE);
			vals_in_list++;
			prev_value = v;
			return 1;
		endfunction

		// returns 1 when the item was taken into a list, 0 when it was ignored
		function bit note_word(logic [WORD_W-1:0] w, logic lst);
			int unsigned next_v;
			int unsigned stp;
			logic [ERR_W-1:0] err;
			bit done;
			err = ERR_NONE;
			done = 0;
			have_held = 0;
			if (stopped) begin
				if (lst)
					clear_list();
				return 0;
			end
			if (w == '0) begin
				done = 1;
			end else begin
				words_in_list++;
				if (step_waiting) begin
					stp = step_size;
					step_waiting = 0;
					step_size = 0;
					if (stp == 0) begin
						err = ERR_ZERO_STEP;
					end else if (w < prev_value) begin
						err = ERR_END_BELOW;
					end else begin
						next_v = prev_value + stp;
						while (err == ERR_NONE && next_v <= w) begin
							if (!take_value(next_v[WORD_W-1:0]))
								err = ERR_CAPACITY;
							next_v += stp;
						end
						// end value is emitted on its own when the steps miss it
						if (err == ERR_NONE && prev_value != w) begin
							if (!take_value(w))
								err = ERR_CAPACITY;
						end
					end
				end else if (w[WORD_W-1:STEP_W] == STEP_TAG) begin
					if (vals_in_list == 0) begin
						err = ERR_NO_BASE;
					end else begin
						step_size = 32'(w[STEP_W-1:0]);
						step_waiting = 1;
					end
				end else if (!take_value(w)) begin
					err = ERR_CAPACITY;
				end
				if (lst || words_in_list >= MAX_WORDS)
					done = 1;
			end
			if (err == ERR_NONE && done) begin
				if (step_waiting)
					err = ERR_UNTERM;
				else if (vals_in_list == 0)
					err = ERR_EMPTY;
			end
			if (err != ERR_NONE)
				queue_result('0, KIND_FAIL, err);
			else if (done)
				queue_result('0, KIND_OK, ERR_NONE);
			if (err != ERR_NONE || done) begin
				clear_list();
				if (!lst)
					stopped = 1;
			end
			if (have_held) begin
				held.last = 1'b1;
				awaited.push_back(held);
				have_held = 0;
			end
			return 1;
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_result(logic [WORD_W-1:0] v, logic [KIND_W-1:0] k,
				logic [ERR_W-1:0] e, logic l);
			dpi_result_t exp;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result value %0d kind %0d code %0d last %0d",
					v, k, e, l));
			end else begin
				exp = awaited.pop_front();
				if (v !== exp.value || k !== exp.kind || e !== exp.code || l !== exp.last)
					report($sformatf("got value %0d kind %0d code %0d last %0d, want %0d %0d %0d %0d",
						v, k, e, l, exp.value, exp.kind, exp.code, exp.last));
				if (exp.kind == KIND_VALUE)
					values_checked++;
				else
					ends_checked++;
				if (exp.kind == KIND_FAIL)
					codes_seen[exp.code] = 1'b1;
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [CAP_W-1:0]  cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [WORD_W-1:0] raw_word = '0;
	logic              word_last = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [WORD_W-1:0] dpi_value;
	logic [KIND_W-1:0] kind;
	logic [ERR_W-1:0]  error_code;
	logic              last_of_run;

	range_scoreboard sb;
	int unsigned burst_left = 0;
	int unsigned live_items = 0;
	int unsigned quiet_cycles = 0;
	bit          hold_req = 1'b0;

	dpi_list_range_expander dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.raw_word    (raw_word),
		.word_last   (word_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.dpi_value   (dpi_value),
		.kind        (kind),
		.error_code  (error_code),
		.last_of_run (last_of_run)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(dpi_value, kind, error_code, last_of_run);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("FAIL dpi_list_range_expander");
				$finish;
			end
		end
	end

	// receiver: stretches of differing stall patterns, plus one long hold on request
	initial begin : receiver
		int mode;
		int span;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 120);
			for (int k = 0; k < span; k++) begin
				@(negedge clk);
				if (hold_req) begin
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES - 1) @(negedge clk);
					hold_req = 1'b0;
				end else begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 1) == 1);
						2: out_stall <= (k % 4 == 3);
						default: out_stall <= ($urandom_range(0, 9) < 7);
					endcase
				end
			end
		end
	end

	task automatic send_word(input logic [WORD_W-1:0] w, input logic lst);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		raw_word <= w;
		word_last <= lst;
		do @(posedge clk); while (!(in_valid && !in_stall));
		if (sb.note_word(w, lst))
			live_items++;
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic wait_drained();
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_capacity(input int unsigned c);
		idle_input();
		wait_drained();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c[CAP_W-1:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.capacity = c;
	endtask

	// a stopped list swallows words until one marked last
	task automatic resync();
		int n;
		if (sb.stopped) begin
			n = $urandom_range(0, 2);
			repeat (n) send_word(WORD_W'($urandom_range(0, 16'hFFFF)), 1'b0);
			send_word(WORD_W'($urandom_range(0, 16'hFFFF)), 1'b1);
		end
	endtask

	task automatic send_good_list();
		int nwords;
		int ending;
		int pos;
		int cur;
		int stp;
		int reps;
		int endv;
		bit fin;
		nwords = $urandom_range(1, MAX_WORDS);
		ending = $urandom_range(0, 3);
		cur = $urandom_range(1, 2000);
		pos = 0;
		while (pos < nwords) begin
			if (pos > 0 && pos + 2 <= nwords && $urandom_range(0, 2) != 0) begin
				stp = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8191) : $urandom_range(1, 40);
				reps = $urandom_range(0, 6);
				endv = cur + stp * reps + $urandom_range(0, stp - 1);
				if (endv > 16'hFFFF)
					endv = 16'hFFFF;
				fin = (pos + 2 == nwords) && (ending < 2);
				send_word({STEP_TAG, stp[STEP_W-1:0]}, 1'b0);
				send_word(endv[WORD_W-1:0], fin);
				cur = endv;
				pos += 2;
			end else begin
				// plain words must stay clear of the step tag
				cur = cur + $urandom_range(0, 3000);
				if (cur > 16'hDFFF)
					cur = 16'hDFFF;
				fin = (pos + 1 == nwords) && (ending < 2);
				send_word(cur[WORD_W-1:0], fin);
				pos++;
			end
		end
		if (ending >= 2 && nwords < MAX_WORDS)
			send_word('0, 1'($urandom_range(0, 1)));
		resync();
	endtask

	task automatic send_noise();
		int n;
		logic [WORD_W-1:0] w;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: w = WORD_W'($urandom_range(0, 16'hFFFF));
				1: w = {STEP_TAG, 13'($urandom_range(0, 16'h1FFF))};
				2: w = '0;
				default: w = WORD_W'($urandom_range(1, 300));
			endcase
			send_word(w, $urandom_range(0, 3) == 0);
		end
		resync();
	endtask

	initial begin : stimulus
		int unsigned caps[8];
		int unsigned goal;
		sb = new();
		caps = '{1, 64, 2, 0, 64, 5, 0, 64};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty list, then a marked word that only restarts
		send_word(16'h0000, 1'b0);
		send_word(16'hFFFF, 1'b1);
		// landing range, missing range, end equal to previous, step at the word limit
		send_word(16'd5, 1'b0);
		send_word(16'hE003, 1'b0);
		send_word(16'd20, 1'b0);
		send_word(16'hE004, 1'b0);
		send_word(16'd27, 1'b0);
		send_word(16'hE005, 1'b0);
		send_word(16'd27, 1'b0);
		send_word(16'hE001, 1'b0);
		send_word(16'h2AAA, 1'b1);
		// range with no base
		send_word(16'hE001, 1'b1);
		// zero step
		send_word(16'd7, 1'b0);
		send_word(16'hE000, 1'b0);
		send_word(16'd9, 1'b1);
		// end below previous
		send_word(16'd100, 1'b0);
		send_word(16'hE002, 1'b0);
		send_word(16'd50, 1'b1);
		// range left open by the marked word
		send_word(16'd3, 1'b0);
		send_word(16'hE001, 1'b1);
		// widest step up to a tagged end word
		send_word(16'd1, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'hFFFF, 1'b1);
		// overflow of the full capacity
		send_word(16'd1, 1'b0);
		send_word(16'hE001, 1'b0);
		send_word(16'd70, 1'b1);
		// largest plain word, then a zero word marked last
		send_word(16'hDFFF, 1'b0);
		send_word(16'h0000, 1'b1);

		// capacity shrinks while a range is pending
		send_word(16'd4, 1'b0);
		send_word(16'hE002, 1'b0);
		write_capacity(3);
		send_word(16'd20, 1'b1);

		foreach (caps[p]) begin
			write_capacity(caps[p] != 0 ? caps[p] : $urandom_range(1, 64));
			if (p == 4)
				hold_req = 1'b1;
			goal = live_items + PHASE_ITEMS;
			while (live_items < goal) begin
				if ($urandom_range(0, 4) == 0)
					send_noise();
				else
					send_good_list();
			end
		end

		idle_input();
		wait_drained();
		$display("run covered %0d list words, %0d values and %0d list ends checked",
			live_items, sb.values_checked, sb.ends_checked);
		$display("failure codes seen (bit per code) %b, capacities 1 to 64, one %0d-cycle hold",
			sb.codes_seen, HOLD_CYCLES);
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("PASS dpi_list_range_expander");
		else
			$display("FAIL dpi_list_range_expander");
		$finish;
	end

endmodule
